// ===== rtl/bdpe_pkg.sv =====
// Package for the button debounce / press event unit.
// Holds field widths, configuration register indexes, event codes and reset values.
// No dependencies.
package bdpe_pkg;

   // Default widths of the internal counters
   localparam int INTEGRATOR_WIDTH_DEFAULT = 8;
   localparam int HOLD_COUNT_WIDTH_DEFAULT = 16;

   // Fixed field widths
   localparam int INTEG_MAX_WIDTH  = 8;
   localparam int LONG_TICKS_WIDTH = 16;
   localparam int CSR_INDEX_WIDTH  = 3;
   localparam int CSR_DATA_WIDTH   = 16;
   localparam int EVENT_WIDTH      = 2;

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_ACTIVE_HIGH        = 3'd0,
      CSR_DEBOUNCE_BYPASS    = 3'd1,
      CSR_INTEGRATOR_MAX     = 3'd2,
      CSR_LONG_PRESS_TICKS   = 3'd3,
      CSR_SHORT_ENABLE       = 3'd4,
      CSR_RELEASE_ENABLE     = 3'd5,
      CSR_LONG_ENABLE        = 3'd6,
      CSR_RELEASE_AFTER_LONG = 3'd7
   } csr_index_type;

   // Event codes
   typedef enum logic [EVENT_WIDTH-1:0] {
      EV_NONE    = 2'd0,
      EV_PRESS   = 2'd1,
      EV_RELEASE = 2'd2,
      EV_LONG    = 2'd3
   } event_type;

   // Configuration register set
   typedef struct packed {
      logic                        active_high;
      logic                        debounce_bypass;
      logic [INTEG_MAX_WIDTH-1:0]  integrator_max;
      logic [LONG_TICKS_WIDTH-1:0] long_press_ticks;
      logic                        short_enable;
      logic                        release_enable;
      logic                        long_enable;
      logic                        release_after_long;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      active_high:        1'b1,
      debounce_bypass:    1'b0,
      integrator_max:     8'd8,
      long_press_ticks:   16'd1000,
      short_enable:       1'b1,
      release_enable:     1'b1,
      long_enable:        1'b1,
      release_after_long: 1'b0
   };

endpackage

// ===== rtl/bdpe_req_if.sv =====
// Input channel: one raw button level per word.
// Depends on nothing.
interface bdpe_req_if;
   logic valid;
   logic ready;
   logic raw_level;

   modport source (output valid, output raw_level, input ready);
   modport sink   (input valid, input raw_level, output ready);
endinterface

// ===== rtl/bdpe_rsp_if.sv =====
// Result channel: event code, debounced level and held flag per word.
// Depends on bdpe_pkg.
interface bdpe_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [bdpe_pkg::EVENT_WIDTH-1:0] event_code;
   logic                             debounced_level;
   logic                             held;

   modport source (output valid, output event_code, output debounced_level,
                   output held, input ready);
   modport sink   (input valid, input event_code, input debounced_level,
                   input held, output ready);
endinterface

// ===== rtl/bdpe_csr_if.sv =====
// Configuration write channel: register index and write data.
// Depends on bdpe_pkg.
interface bdpe_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [bdpe_pkg::CSR_INDEX_WIDTH-1:0] index;
   logic [bdpe_pkg::CSR_DATA_WIDTH-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/button_debounce_press_events_unit.sv =====
// Button debounce with press, release and long-press events.
// Depends on bdpe_pkg, bdpe_req_if, bdpe_rsp_if, bdpe_csr_if.
//
//   channel | dir | handshake   | payload
//   req_ch  | in  | valid/ready | raw_level
//   rsp_ch  | out | valid/ready | event_code, debounced_level, held
//   csr_ch  | in  | valid/ready | index, data (always ready)
//
// Each word is processed combinationally and registered; the result shows in the cycle after accept.
// One word per cycle is sustained while results are taken; the single output register sets the latency.
// A new word is taken while the result register is empty or being drained.
// Reset is synchronous: state clears and registers return to their defaults.
module button_debounce_press_events_unit #(
   parameter int INTEGRATOR_WIDTH = bdpe_pkg::INTEGRATOR_WIDTH_DEFAULT,
   parameter int HOLD_COUNT_WIDTH = bdpe_pkg::HOLD_COUNT_WIDTH_DEFAULT
) (
   input logic         clock,
   input logic         reset,
   bdpe_req_if.sink    req_ch,
   bdpe_rsp_if.source  rsp_ch,
   bdpe_csr_if.sink    csr_ch
);

   // Compare widths wide enough for counter and configured limit
   localparam int IW = INTEGRATOR_WIDTH;
   localparam int HW = HOLD_COUNT_WIDTH;
   localparam int ICW = (IW > bdpe_pkg::INTEG_MAX_WIDTH) ? IW : bdpe_pkg::INTEG_MAX_WIDTH;
   localparam int HCW = (HW > bdpe_pkg::LONG_TICKS_WIDTH) ? HW : bdpe_pkg::LONG_TICKS_WIDTH;

   bdpe_pkg::cfg_type cfg_ff, cfg_in;

   logic [IW-1:0] integ_ff, integ_in;
   logic          level_ff, level_in;
   logic          level_before_ff;
   logic          press_held_ff, press_held_in;
   logic          long_fired_ff, long_fired_in;
   logic [HW-1:0] hold_ff, hold_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   bdpe_pkg::event_type  event_ff, event_in;

   logic           accept;
   logic           raw;
   logic [IW-1:0]  integ_step;
   logic [ICW-1:0] integ_ext, step_ext, max_ext;
   logic [HCW-1:0] hold_ext, ticks_ext;
   logic           now_p, before_p;
   logic [HW-1:0]  hold_mid;

   // Accept while the result register is free or draining
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign raw          = req_ch.raw_level;
   assign csr_ch.ready = 1'b1;

   // Decode configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (bdpe_pkg::csr_index_type'(csr_ch.index))
            bdpe_pkg::CSR_ACTIVE_HIGH:        cfg_in.active_high = csr_ch.data[0];
            bdpe_pkg::CSR_DEBOUNCE_BYPASS:    cfg_in.debounce_bypass = csr_ch.data[0];
            bdpe_pkg::CSR_INTEGRATOR_MAX:
               cfg_in.integrator_max = csr_ch.data[bdpe_pkg::INTEG_MAX_WIDTH-1:0];
            bdpe_pkg::CSR_LONG_PRESS_TICKS:
               cfg_in.long_press_ticks = csr_ch.data[bdpe_pkg::LONG_TICKS_WIDTH-1:0];
            bdpe_pkg::CSR_SHORT_ENABLE:       cfg_in.short_enable = csr_ch.data[0];
            bdpe_pkg::CSR_RELEASE_ENABLE:     cfg_in.release_enable = csr_ch.data[0];
            bdpe_pkg::CSR_LONG_ENABLE:        cfg_in.long_enable = csr_ch.data[0];
            bdpe_pkg::CSR_RELEASE_AFTER_LONG: cfg_in.release_after_long = csr_ch.data[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   // Integrator, level, event decision and hold counter
   always_comb begin
      max_ext   = ICW'(cfg_ff.integrator_max);
      integ_ext = ICW'(integ_ff);

      // Step toward the raw level
      if (!raw) begin
         integ_step = (integ_ff != '0) ? integ_ff - IW'(1) : integ_ff;
      end else if (integ_ext < max_ext) begin
         integ_step = integ_ff + IW'(1);
      end else begin
         integ_step = integ_ff;
      end
      step_ext = ICW'(integ_step);

      // Settle the level at either end; clamp above the maximum
      integ_in = integ_step;
      level_in = level_ff;
      if (integ_step == '0) begin
         level_in = 1'b0;
      end else if (step_ext >= max_ext) begin
         integ_in = max_ext[IW-1:0];
         level_in = 1'b1;
      end
      if (cfg_ff.debounce_bypass) begin
         level_in = raw;
      end

      now_p    = cfg_ff.active_high ? level_in : !level_in;
      before_p = cfg_ff.active_high ? level_before_ff : !level_before_ff;

      hold_ext  = HCW'(hold_ff);
      ticks_ext = HCW'(cfg_ff.long_press_ticks);

      // Pick one event: press edge, then release edge, then long press
      event_in      = bdpe_pkg::EV_NONE;
      press_held_in = press_held_ff;
      long_fired_in = long_fired_ff;
      hold_mid      = hold_ff;
      if (now_p && !before_p && !press_held_ff) begin
         press_held_in = 1'b1;
         if (cfg_ff.short_enable) begin
            event_in = bdpe_pkg::EV_PRESS;
         end
      end else if (!now_p && before_p && press_held_ff) begin
         if (cfg_ff.release_enable &&
             (!cfg_ff.long_enable || cfg_ff.release_after_long || !long_fired_ff)) begin
            event_in = bdpe_pkg::EV_RELEASE;
         end
         long_fired_in = 1'b0;
         hold_mid      = '0;
         press_held_in = 1'b0;
      end else if (cfg_ff.long_enable && press_held_ff && !long_fired_ff &&
                   hold_ext >= ticks_ext) begin
         event_in      = bdpe_pkg::EV_LONG;
         long_fired_in = 1'b1;
         hold_mid      = '0;
      end

      // Advance the hold counter, saturating at all ones
      hold_in = hold_mid;
      if (press_held_in && !long_fired_in && hold_mid != '1) begin
         hold_in = hold_mid + HW'(1);
      end

      // Result register: load on accept, drop when taken
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff          <= bdpe_pkg::CFG_RESET;
         integ_ff        <= '0;
         level_ff        <= 1'b0;
         level_before_ff <= 1'b0;
         press_held_ff   <= 1'b0;
         long_fired_ff   <= 1'b0;
         hold_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            integ_ff        <= integ_in;
            level_ff        <= level_in;
            level_before_ff <= level_in;
            press_held_ff   <= press_held_in;
            long_fired_ff   <= long_fired_in;
            hold_ff         <= hold_in;
         end
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         event_ff <= event_in;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.event_code      = event_ff;
   assign rsp_ch.debounced_level = level_ff;
   assign rsp_ch.held            = press_held_ff;

   // A press word always shows the press as held
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && event_ff == bdpe_pkg::EV_PRESS |-> press_held_ff)
      else $error("press event without held");

   // A release word always shows the press as gone
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && event_ff == bdpe_pkg::EV_RELEASE |-> !press_held_ff)
      else $error("release event while held");

   // A long press only stands within a held press
   assert property (@(posedge clock) disable iff (reset)
      long_fired_ff |-> press_held_ff)
      else $error("long press flag outside a press");

   // A waiting result word holds until it is taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ch.ready |=> rsp_valid_ff && $stable(event_ff) &&
         $stable(level_ff) && $stable(press_held_ff))
      else $error("result word changed while stalled");

endmodule

// ===== verif/button_debounce_press_events_unit_test.sv =====
// Self-checking bench for button_debounce_press_events_unit: ticks of the raw pin
// level are replayed against a cycle-free debounce and press-event predictor.
// Depends on bdpe_pkg, bdpe_req_if, bdpe_rsp_if, bdpe_csr_if and the unit itself.
module button_debounce_press_events_unit_test;

   localparam int HOLD_MAX_CYCLES = 5_000_000;

   typedef enum {OP_TICK, OP_CSR_WRITE, OP_WAIT_DRAIN} plan_op_type;

   typedef struct {
      plan_op_type                         op;
      logic                                raw;
      bdpe_pkg::csr_index_type             idx;
      logic [bdpe_pkg::CSR_DATA_WIDTH-1:0] data;
   } plan_entry_type;

   typedef struct {
      bdpe_pkg::event_type ev;
      logic                level;
      logic                held;
   } press_word_type;

   logic clock;
   logic reset = 1'b1;

   bdpe_req_if req_ch ();
   bdpe_rsp_if rsp_ch ();
   bdpe_csr_if csr_ch ();

   button_debounce_press_events_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Stimulus plan and the register set it assumes while being built
   plan_entry_type    tick_plan[$];
   bdpe_pkg::cfg_type plan_cfg = bdpe_pkg::CFG_RESET;
   int unsigned       planned_ticks = 0;

   // Predictor state: configuration plus debounce and hold tracking
   bdpe_pkg::cfg_type                             model_cfg   = bdpe_pkg::CFG_RESET;
   logic [bdpe_pkg::INTEGRATOR_WIDTH_DEFAULT-1:0] integ_count = '0;
   logic                                          level_q     = 1'b0;
   logic                                          level_prev  = 1'b0;
   logic                                          press_on    = 1'b0;
   logic                                          long_done   = 1'b0;
   logic [bdpe_pkg::HOLD_COUNT_WIDTH_DEFAULT-1:0] hold_count  = '0;

   press_word_type predicted_words[$];

   // Handshake bookkeeping between the sampling and driving edges
   bit          req_taken = 1'b0;
   bit          csr_taken = 1'b0;
   int unsigned words_sent = 0;
   int unsigned writes_done = 0;
   int unsigned failures = 0;
   int unsigned event_seen[4] = '{0, 0, 0, 0};

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hold reset, then release it between edges
   initial begin
      req_ch.valid     = 1'b0;
      req_ch.raw_level = 1'b0;
      rsp_ch.ready     = 1'b0;
      csr_ch.valid     = 1'b0;
      csr_ch.index     = bdpe_pkg::CSR_ACTIVE_HIGH;
      csr_ch.data      = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
   end

   // Apply one register write to a configuration image
   function automatic bdpe_pkg::cfg_type cfg_apply(bdpe_pkg::cfg_type c,
                                                   bdpe_pkg::csr_index_type idx,
                                                   logic [bdpe_pkg::CSR_DATA_WIDTH-1:0] d);
      case (idx)
         bdpe_pkg::CSR_ACTIVE_HIGH:        c.active_high        = d[0];
         bdpe_pkg::CSR_DEBOUNCE_BYPASS:    c.debounce_bypass    = d[0];
         bdpe_pkg::CSR_INTEGRATOR_MAX:
            c.integrator_max = d[bdpe_pkg::INTEG_MAX_WIDTH-1:0];
         bdpe_pkg::CSR_LONG_PRESS_TICKS:
            c.long_press_ticks = d[bdpe_pkg::LONG_TICKS_WIDTH-1:0];
         bdpe_pkg::CSR_SHORT_ENABLE:       c.short_enable       = d[0];
         bdpe_pkg::CSR_RELEASE_ENABLE:     c.release_enable     = d[0];
         bdpe_pkg::CSR_LONG_ENABLE:        c.long_enable        = d[0];
         bdpe_pkg::CSR_RELEASE_AFTER_LONG: c.release_after_long = d[0];
         default: ;
      endcase
      return c;
   endfunction

   // Advance the predictor by one tick and return the word it should produce
   function automatic press_word_type debounce_tick(logic raw);
      press_word_type w;
      logic           now_p;
      logic           before_p;
      w.ev = bdpe_pkg::EV_NONE;
      // saturating integrator
      if (!raw) begin
         if (integ_count != 0) integ_count = integ_count - 1'b1;
      end else if (integ_count < model_cfg.integrator_max) begin
         integ_count = integ_count + 1'b1;
      end
      if (integ_count == 0) begin
         level_q = 1'b0;
      end else if (integ_count >= model_cfg.integrator_max) begin
         integ_count = model_cfg.integrator_max;
         level_q     = 1'b1;
      end
      if (model_cfg.debounce_bypass) level_q = raw;
      // edges judged against the active polarity
      now_p    = model_cfg.active_high ? level_q : !level_q;
      before_p = model_cfg.active_high ? level_prev : !level_prev;
      if (now_p && !before_p && !press_on) begin
         press_on = 1'b1;
         if (model_cfg.short_enable) w.ev = bdpe_pkg::EV_PRESS;
      end else if (!now_p && before_p && press_on) begin
         if (model_cfg.release_enable && (!model_cfg.long_enable ||
             model_cfg.release_after_long || !long_done))
            w.ev = bdpe_pkg::EV_RELEASE;
         long_done  = 1'b0;
         hold_count = '0;
         press_on   = 1'b0;
      end else if (model_cfg.long_enable && press_on && !long_done &&
                   hold_count >= model_cfg.long_press_ticks) begin
         w.ev       = bdpe_pkg::EV_LONG;
         long_done  = 1'b1;
         hold_count = '0;
      end
      level_prev = level_q;
      // hold counter saturates at all ones
      if (press_on && !long_done && hold_count != '1) hold_count = hold_count + 1'b1;
      w.level = level_q;
      w.held  = press_on;
      return w;
   endfunction

   // Plan building helpers
   function automatic void queue_tick(logic raw);
      plan_entry_type e;
      e.op   = OP_TICK;
      e.raw  = raw;
      e.idx  = bdpe_pkg::CSR_ACTIVE_HIGH;
      e.data = '0;
      tick_plan.push_back(e);
      planned_ticks++;
   endfunction

   function automatic void queue_level(logic lvl, int unsigned len, int unsigned glitch_pct);
      for (int unsigned i = 0; i < len; i++)
         queue_tick(($urandom_range(99) < glitch_pct) ? !lvl : lvl);
   endfunction

   function automatic void queue_write(bdpe_pkg::csr_index_type idx,
                                       logic [bdpe_pkg::CSR_DATA_WIDTH-1:0] d);
      plan_entry_type e;
      e.op   = OP_CSR_WRITE;
      e.raw  = 1'b0;
      e.idx  = idx;
      e.data = d;
      tick_plan.push_back(e);
      plan_cfg = cfg_apply(plan_cfg, idx, d);
   endfunction

   function automatic void queue_drain();
      plan_entry_type e;
      e.op   = OP_WAIT_DRAIN;
      e.raw  = 1'b0;
      e.idx  = bdpe_pkg::CSR_ACTIVE_HIGH;
      e.data = '0;
      tick_plan.push_back(e);
   endfunction

   // Pick a new setting, touching each register about half the time
   function automatic void queue_random_config();
      int unsigned r;
      if ($urandom_range(1))
         queue_write(bdpe_pkg::CSR_ACTIVE_HIGH, 16'($urandom_range(1)));
      if ($urandom_range(1))
         queue_write(bdpe_pkg::CSR_DEBOUNCE_BYPASS, 16'($urandom_range(99) < 20));
      if ($urandom_range(1)) begin
         r = $urandom_range(99);
         if (r < 5)
            queue_write(bdpe_pkg::CSR_INTEGRATOR_MAX, 16'd0);
         else if (r < 15)
            queue_write(bdpe_pkg::CSR_INTEGRATOR_MAX, 16'd255);
         else if (r < 80)
            queue_write(bdpe_pkg::CSR_INTEGRATOR_MAX, 16'($urandom_range(1, 10)));
         else
            queue_write(bdpe_pkg::CSR_INTEGRATOR_MAX, 16'($urandom_range(1, 255)));
      end
      if ($urandom_range(1)) begin
         r = $urandom_range(99);
         if (r < 10)
            queue_write(bdpe_pkg::CSR_LONG_PRESS_TICKS, 16'd0);
         else if (r < 15)
            queue_write(bdpe_pkg::CSR_LONG_PRESS_TICKS, 16'hFFFF);
         else if (r < 80)
            queue_write(bdpe_pkg::CSR_LONG_PRESS_TICKS, 16'($urandom_range(1, 30)));
         else
            queue_write(bdpe_pkg::CSR_LONG_PRESS_TICKS, 16'($urandom_range(31, 300)));
      end
      if ($urandom_range(1))
         queue_write(bdpe_pkg::CSR_SHORT_ENABLE, 16'($urandom_range(99) < 80));
      if ($urandom_range(1))
         queue_write(bdpe_pkg::CSR_RELEASE_ENABLE, 16'($urandom_range(99) < 80));
      if ($urandom_range(1))
         queue_write(bdpe_pkg::CSR_LONG_ENABLE, 16'($urandom_range(99) < 80));
      if ($urandom_range(1))
         queue_write(bdpe_pkg::CSR_RELEASE_AFTER_LONG, 16'($urandom_range(1)));
   endfunction

   // Mostly press/release gestures with bounce, some plain pin noise
   function automatic void queue_random_traffic(int unsigned target);
      int unsigned budget_end;
      int unsigned long_span;
      while (planned_ticks < target) begin
         if ($urandom_range(3) == 0) queue_drain();
         queue_random_config();
         budget_end = planned_ticks + $urandom_range(60, 160);
         while (planned_ticks < budget_end) begin
            if ($urandom_range(99) < 15) begin
               queue_level(1'b0, $urandom_range(3, 20), 50);
            end else begin
               long_span = (plan_cfg.long_press_ticks > 300) ? 300 : plan_cfg.long_press_ticks;
               queue_level(plan_cfg.active_high,
                           $urandom_range(1, plan_cfg.integrator_max + long_span + 8), 8);
               queue_level(!plan_cfg.active_high,
                           $urandom_range(1, plan_cfg.integrator_max + 8), 8);
            end
         end
      end
   endfunction

   function automatic bit idle_now();
      return !(words_sent >= 300 && words_sent < 700) && $urandom_range(99) < 6;
   endfunction

   function automatic void flag_failure(string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
   endfunction

   // Drive words and writes on the falling edge
   always @(negedge clock) begin
      plan_entry_type                       head;
      logic                                 nv;
      logic                                 nraw;
      logic                                 ncv;
      logic [bdpe_pkg::CSR_INDEX_WIDTH-1:0] nidx;
      logic [bdpe_pkg::CSR_DATA_WIDTH-1:0]  ndata;
      nv    = req_ch.valid;
      nraw  = req_ch.raw_level;
      ncv   = csr_ch.valid;
      nidx  = csr_ch.index;
      ndata = csr_ch.data;
      if (reset) begin
         nv  = 1'b0;
         ncv = 1'b0;
      end else begin
         // retire what the last rising edge took
         if (req_taken) begin
            req_taken = 1'b0;
            nv        = 1'b0;
            void'(tick_plan.pop_front());
         end
         if (csr_taken) begin
            csr_taken = 1'b0;
            ncv       = 1'b0;
            void'(tick_plan.pop_front());
         end
         if (!nv && !ncv && tick_plan.size() != 0) begin
            head = tick_plan[0];
            case (head.op)
               OP_TICK: begin
                  if (!idle_now()) begin
                     nv   = 1'b1;
                     nraw = head.raw;
                  end
               end
               OP_CSR_WRITE: begin
                  // write only once the unit has drained
                  if (predicted_words.size() == 0) begin
                     ncv   = 1'b1;
                     nidx  = head.idx;
                     ndata = head.data;
                  end
               end
               OP_WAIT_DRAIN: begin
                  if (predicted_words.size() == 0) void'(tick_plan.pop_front());
               end
               default: ;
            endcase
         end
      end
      req_ch.valid     <= nv;
      req_ch.raw_level <= nraw;
      csr_ch.valid     <= ncv;
      csr_ch.index     <= nidx;
      csr_ch.data      <= ndata;
      rsp_ch.ready     <= !reset && !idle_now();
   end

   // Sample handshakes on the rising edge: check results, then predict new words
   always @(posedge clock) begin
      press_word_type want;
      press_word_type got;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (predicted_words.size() == 0) begin
               flag_failure($sformatf(
                  "result word with nothing pending: event %0d level %0d held %0d",
                  rsp_ch.event_code, rsp_ch.debounced_level, rsp_ch.held));
            end else begin
               want = predicted_words.pop_front();
               got.ev    = bdpe_pkg::event_type'(rsp_ch.event_code);
               got.level = rsp_ch.debounced_level;
               got.held  = rsp_ch.held;
               if (got.ev !== want.ev || got.level !== want.level || got.held !== want.held)
                  flag_failure($sformatf(
                     {"mismatch at %0t: event exp %0d got %0d, level exp %0d got %0d,",
                      " held exp %0d got %0d"},
                     $realtime, want.ev, rsp_ch.event_code, want.level, rsp_ch.debounced_level,
                     want.held, rsp_ch.held));
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            want = debounce_tick(req_ch.raw_level);
            event_seen[want.ev]++;
            predicted_words.push_back(want);
            req_taken = 1'b1;
            words_sent++;
         end
         if (csr_ch.valid && csr_ch.ready) begin
            model_cfg = cfg_apply(model_cfg, bdpe_pkg::csr_index_type'(csr_ch.index),
                                  csr_ch.data);
            csr_taken = 1'b1;
            writes_done++;
         end
      end
   end

   // Build the plan, then wait for it to play out and report
   initial begin
      // press, immediate long event, release held back after it
      queue_write(bdpe_pkg::CSR_INTEGRATOR_MAX, 16'd1);
      queue_write(bdpe_pkg::CSR_LONG_PRESS_TICKS, 16'd0);
      queue_tick(1'b1);
      queue_tick(1'b1);
      queue_tick(1'b0);
      // release after long allowed
      queue_write(bdpe_pkg::CSR_RELEASE_AFTER_LONG, 16'd1);
      queue_tick(1'b1);
      queue_tick(1'b1);
      queue_tick(1'b0);
      // all events off: press state still tracks
      queue_write(bdpe_pkg::CSR_SHORT_ENABLE, 16'd0);
      queue_write(bdpe_pkg::CSR_RELEASE_ENABLE, 16'd0);
      queue_write(bdpe_pkg::CSR_LONG_ENABLE, 16'd0);
      queue_tick(1'b1);
      queue_tick(1'b1);
      queue_tick(1'b0);
      queue_write(bdpe_pkg::CSR_SHORT_ENABLE, 16'd1);
      queue_write(bdpe_pkg::CSR_RELEASE_ENABLE, 16'd1);
      queue_write(bdpe_pkg::CSR_LONG_ENABLE, 16'd1);
      // active low polarity
      queue_write(bdpe_pkg::CSR_ACTIVE_HIGH, 16'd0);
      queue_tick(1'b1);
      queue_tick(1'b0);
      queue_tick(1'b1);
      // bypass with a slow integrator, then leave bypass with the level held
      queue_write(bdpe_pkg::CSR_ACTIVE_HIGH, 16'd1);
      queue_write(bdpe_pkg::CSR_DEBOUNCE_BYPASS, 16'd1);
      queue_write(bdpe_pkg::CSR_INTEGRATOR_MAX, 16'd255);
      queue_tick(1'b1);
      queue_tick(1'b1);
      queue_tick(1'b0);
      queue_tick(1'b1);
      queue_write(bdpe_pkg::CSR_DEBOUNCE_BYPASS, 16'd0);
      queue_tick(1'b0);
      queue_tick(1'b1);
      // maximum lowered under the count, then maximum of zero
      queue_write(bdpe_pkg::CSR_INTEGRATOR_MAX, 16'd1);
      queue_tick(1'b1);
      queue_write(bdpe_pkg::CSR_INTEGRATOR_MAX, 16'd0);
      queue_tick(1'b1);
      queue_tick(1'b0);
      queue_drain();

      queue_random_traffic(planned_ticks + 480);

      // hold counts with long off, then long fires at once when enabled mid-press
      queue_drain();
      queue_write(bdpe_pkg::CSR_DEBOUNCE_BYPASS, 16'd1);
      queue_write(bdpe_pkg::CSR_ACTIVE_HIGH, 16'd1);
      queue_write(bdpe_pkg::CSR_LONG_ENABLE, 16'd0);
      queue_write(bdpe_pkg::CSR_LONG_PRESS_TICKS, 16'd20);
      queue_write(bdpe_pkg::CSR_RELEASE_AFTER_LONG, 16'd0);
      queue_level(1'b0, 3, 0);
      queue_level(1'b1, 40, 0);
      queue_write(bdpe_pkg::CSR_LONG_ENABLE, 16'd1);
      queue_level(1'b1, 3, 0);
      queue_tick(1'b0);

      queue_random_traffic(planned_ticks + 500);

      while (tick_plan.size() != 0 || predicted_words.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (predicted_words.size() != 0)
         flag_failure($sformatf("%0d result words never arrived", predicted_words.size()));

      $display("Ran %0d ticks through %0d register writes; events: %0d press, %0d release, %0d long.",
               words_sent, writes_done, event_seen[bdpe_pkg::EV_PRESS],
               event_seen[bdpe_pkg::EV_RELEASE], event_seen[bdpe_pkg::EV_LONG]);
      $display("Result words checked with %0d failures.", failures);
      if (failures == 0) begin
         $display("button_debounce_press_events_unit_test: PASS");
      end else begin
         $display("button_debounce_press_events_unit_test: FAIL");
      end
      $finish;
   end

   // Hard stop if the run hangs
   initial begin
      #(HOLD_MAX_CYCLES * 10);
      $display("Run stopped by timeout with %0d words pending.", predicted_words.size());
      $display("button_debounce_press_events_unit_test: FAIL");
      $finish;
   end

endmodule
